FILE: hdl/lit_pkg.sv
// Shared types, codes and helpers for the linear inequality tokenizer.
// Used by every module of the block; depends on nothing.
package lit_pkg;

  // Width of the character position counter.
  localparam int PosBits = 16;

  // Token queue between front and back.
  localparam int QDepth   = 4;
  localparam int QPtrBits = $clog2(QDepth);

  typedef logic [PosBits-1:0] pos_t;

  // Request types (s_tuser)
  localparam logic ReqChar = 1'b0;
  localparam logic ReqEnd  = 1'b1;

  // Token kinds
  localparam logic [2:0] KindInt   = 3'd0;
  localparam logic [2:0] KindFloat = 3'd1;
  localparam logic [2:0] KindVar   = 3'd2;
  localparam logic [2:0] KindOp    = 3'd3;
  localparam logic [2:0] KindIneq  = 3'd4;
  localparam logic [2:0] KindErr   = 3'd5;
  localparam logic [2:0] KindEnd   = 3'd6;

  // Character codes
  localparam logic [7:0] ChDigitBelow = 8'd47;  // '/' : digits lie strictly between
  localparam logic [7:0] ChDigitAbove = 8'd58;  // ':'
  localparam logic [7:0] ChDot        = 8'h2E;
  localparam logic [7:0] ChSpace      = 8'h20;
  localparam logic [7:0] ChEq         = 8'h3D;
  localparam logic [7:0] ChPlus       = 8'h2B;
  localparam logic [7:0] ChMinus      = 8'h2D;
  localparam logic [7:0] ChLt         = 8'h3C;
  localparam logic [7:0] ChGt         = 8'h3E;
  localparam logic [7:0] ChUpperA     = 8'h41;
  localparam logic [7:0] ChUpperZ     = 8'h5A;
  localparam logic [7:0] ChLowerA     = 8'h61;
  localparam logic [7:0] ChLowerZ     = 8'h7A;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  chr;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } token_t;

  // One item's worth of results: one or two tokens.
  typedef struct packed {
    token_t first;
    token_t second;
    logic   two;
  } bundle_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  // Clamp a position-wide value to the 16-bit output fields.
  function automatic logic [15:0] sat16(input pos_t v);
    logic [15:0] r;
    if (PosBits > 16 && v > pos_t'(17'h0FFFF)) begin
      r = 16'hFFFF;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

endpackage

FILE: hdl/linear_inequality_tokenizer.sv
// Top level of the linear inequality tokenizer: front end, token queue and
// back end. Depends on lit_pkg, lit_front, lit_fifo and lit_back.
//
// Streaming tokenizer for linear inequality strings. Each input item is one
// character (s_tuser = 0) or an end-of-string marker (s_tuser = 1). The
// front end takes one item per clock whenever the four-entry token queue has
// room, including items that cause no token (spaces, '=', digits inside a
// number run, characters after an error). An item's tokens are written into
// the queue when it is accepted; its first token then moves from the queue
// into the output register that drives m_tvalid. The output port moves one
// token per cycle while m_tready is high, so a run of items that each yield
// one token flows at one item per clock; an item that yields two tokens (a
// number run closed by a token character, or an end marker after a pending
// number) holds the output for both its tokens, and the queue absorbs that
// until it fills, when s_tready drops. tlast marks the last token of an item.
// Number tokens report start position and length only; positions saturate.
module linear_inequality_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [2:0] token_kind, [10:3] token_char,
                                 // [26:11] start_pos, [42:27] token_length,
                                 // [47:43] zero
  output logic        m_tlast    // last_of_run
);
  import lit_pkg::*;

  fifo_status_t q_stat;
  logic         push, pop;
  bundle_t      push_data, pop_data;
  token_t       out_tok;

  lit_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  lit_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  lit_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .pop      (pop),
    .pop_data (pop_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .out_tok  (out_tok)
  );

  // pack the token, first field in the low bits
  assign m_tdata = {5'b0, out_tok.len, out_tok.start, out_tok.chr, out_tok.kind};
  assign m_tlast = out_tok.last;

endmodule

FILE: hdl/lit_front.sv
// Front end: accepts characters, holds the scan state and turns each item
// into a bundle of zero, one or two tokens. Depends on lit_pkg.
module lit_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] char_code
  input  logic                  s_tuser,   // [0] req_type
  input  lit_pkg::fifo_status_t q_stat,
  output logic                  push,
  output lit_pkg::bundle_t      push_data
);
  import lit_pkg::*;

  pos_t char_position, char_position_next;
  pos_t number_start, number_start_next;
  logic number_active, number_active_next;
  logic decimal_seen, decimal_seen_next;
  logic halted_on_error, halted_on_error_next;

  logic   accept;
  logic   digit, letter, is_op, is_ineq, skip;
  pos_t   pos_inc;
  token_t num_tok, chr_tok, end_tok;
  logic   has_chr;

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  assign digit   = (s_tdata > ChDigitBelow) && (s_tdata < ChDigitAbove);
  assign letter  = ((s_tdata >= ChUpperA) && (s_tdata <= ChUpperZ)) ||
                   ((s_tdata >= ChLowerA) && (s_tdata <= ChLowerZ));
  assign is_op   = (s_tdata == ChPlus) || (s_tdata == ChMinus);
  assign is_ineq = (s_tdata == ChLt) || (s_tdata == ChGt);
  assign skip    = (s_tdata == ChSpace) || (s_tdata == ChEq);

  // saturating advance
  assign pos_inc = (char_position == '1) ? char_position : char_position + pos_t'(1);

  always_comb begin
    num_tok.kind  = decimal_seen ? KindFloat : KindInt;
    num_tok.chr   = 8'd0;
    num_tok.start = sat16(number_start);
    num_tok.len   = sat16(char_position - number_start);
    num_tok.last  = 1'b0;

    end_tok.kind  = KindEnd;
    end_tok.chr   = 8'd0;
    end_tok.start = sat16(char_position);
    end_tok.len   = 16'd0;
    end_tok.last  = 1'b1;

    chr_tok.chr   = s_tdata;
    chr_tok.start = sat16(char_position);
    chr_tok.len   = 16'd1;
    chr_tok.last  = 1'b1;
    if (letter) begin
      chr_tok.kind = KindVar;
    end else if (is_op) begin
      chr_tok.kind = KindOp;
    end else if (is_ineq) begin
      chr_tok.kind = KindIneq;
    end else begin
      chr_tok.kind = KindErr;
    end
    has_chr = !skip && !digit;
  end

  always_comb begin
    char_position_next   = char_position;
    number_start_next    = number_start;
    number_active_next   = number_active;
    decimal_seen_next    = decimal_seen;
    halted_on_error_next = halted_on_error;
    push                 = 1'b0;
    push_data            = '0;

    if (accept) begin
      if (s_tuser == ReqEnd) begin
        push = 1'b1;
        if (number_active) begin
          push_data.first  = num_tok;
          push_data.second = end_tok;
          push_data.two    = 1'b1;
        end else begin
          push_data.first = end_tok;
        end
        char_position_next   = '0;
        number_start_next    = '0;
        number_active_next   = 1'b0;
        decimal_seen_next    = 1'b0;
        halted_on_error_next = 1'b0;
      end else if (!halted_on_error) begin
        if (number_active && (digit || (s_tdata == ChDot && !decimal_seen))) begin
          // run continues
          char_position_next = pos_inc;
          if (s_tdata == ChDot) begin
            decimal_seen_next = 1'b1;
          end
        end else begin
          // an open run ends here
          number_active_next = 1'b0;
          decimal_seen_next  = 1'b0;
          if (skip) begin
            char_position_next = pos_inc;
          end else if (digit) begin
            number_active_next = 1'b1;
            number_start_next  = char_position;
            char_position_next = pos_inc;
          end else if (letter || is_op || is_ineq) begin
            char_position_next = pos_inc;
          end else begin
            halted_on_error_next = 1'b1;
          end

          if (number_active) begin
            push            = 1'b1;
            push_data.first = num_tok;
            if (has_chr) begin
              push_data.second = chr_tok;
              push_data.two    = 1'b1;
            end else begin
              push_data.first.last = 1'b1;
            end
          end else if (has_chr) begin
            push            = 1'b1;
            push_data.first = chr_tok;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position   <= '0;
      number_start    <= '0;
      number_active   <= 1'b0;
      decimal_seen    <= 1'b0;
      halted_on_error <= 1'b0;
    end else begin
      char_position   <= char_position_next;
      number_start    <= number_start_next;
      number_active   <= number_active_next;
      decimal_seen    <= decimal_seen_next;
      halted_on_error <= halted_on_error_next;
    end
  end

endmodule

FILE: hdl/lit_fifo.sv
// Short token queue between front and back end, one bundle per entry.
// Depends on lit_pkg.
module lit_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lit_pkg::bundle_t      push_data,
  input  logic                  pop,
  output lit_pkg::bundle_t      pop_data,
  output lit_pkg::fifo_status_t stat
);
  import lit_pkg::*;

  bundle_t             mem [QDepth];
  logic [QPtrBits-1:0] wr_ptr;
  logic [QPtrBits-1:0] rd_ptr;
  logic [QPtrBits:0]   count;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == (QPtrBits+1)'(QDepth));
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/lit_back.sv
// Back end: drains token bundles from the queue and presents one token per
// cycle while m_tready is high, in an output register, holding the second
// token of a pair aside. Depends on lit_pkg.
module lit_back (
  input  logic                  clk,
  input  logic                  rst,
  input  lit_pkg::fifo_status_t q_stat,
  output logic                  pop,
  input  lit_pkg::bundle_t      pop_data,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output lit_pkg::token_t       out_tok
);
  import lit_pkg::*;

  logic   out_valid;
  logic   pend_valid;
  token_t pend_tok;
  logic   load;

  assign load     = !out_valid || m_tready;
  assign pop      = load && !pend_valid && !q_stat.empty;
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (!q_stat.empty) begin
        out_valid  <= 1'b1;
        pend_valid <= pop_data.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid) begin
        out_tok <= pend_tok;
      end else if (!q_stat.empty) begin
        out_tok  <= pop_data.first;
        pend_tok <= pop_data.second;
      end
    end
  end

endmodule

FILE: hdl/lit_checker.sv
// Port-level checks for the linear inequality tokenizer, bound to the top
// level. Depends on linear_inequality_tokenizer's port list and lit_pkg.
module lit_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tlast
);
  import lit_pkg::*;

  // no token right after reset
  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_tvalid)
    else $error("token valid right after reset");

  // stalled token holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled token changed");

  // end marker closes its item and has zero length
  a_end_tok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == KindEnd |-> m_tlast && m_tdata[42:27] == 16'd0)
    else $error("bad end-of-string token");

  // single-character tokens have length one and close their item
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == KindVar || m_tdata[2:0] == KindOp ||
                 m_tdata[2:0] == KindIneq || m_tdata[2:0] == KindErr)
    |-> m_tdata[42:27] == 16'd1 && m_tlast)
    else $error("bad single-character token");

  // number tokens carry no character and at least one digit
  a_number: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == KindInt || m_tdata[2:0] == KindFloat)
    |-> m_tdata[10:3] == 8'd0 && m_tdata[42:27] != 16'd0)
    else $error("bad number token");

endmodule

bind linear_inequality_tokenizer lit_checker u_lit_checker (.*);
